// File: hw/rtl/salru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_pkg: shared types and constants for the LRU tag store
// Default geometry, stream field widths, access kinds and sequencer states.
// ----------------------------------------------------------------------------
package salru_pkg;

    localparam int NumSetsDef   = 64;
    localparam int WaysDef      = 8;
    localparam int LineBytesDef = 64;
    localparam int AddrBitsDef  = 32;

    // Result tdata width: hit..writebacks = 1+1+32+1+1+5*32 = 196 -> 200
    localparam int OutDataW = 200;
    // Request tdata width: address, access kind, is_fill = 35 -> 40
    localparam int InDataW  = 40;

    localparam logic [1:0] AccRead  = 2'd0;
    localparam logic [1:0] AccWrite = 2'd1;
    localparam logic [1:0] AccFetch = 2'd2;
    localparam logic [1:0] AccWback = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_WRITE,
        ST_OUT
    } state_t;

endpackage

// File: hw/rtl/set_assoc_lru_tag_store_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_tag_store_core: tag store of a set-associative LRU cache
// Lookup, LRU update, fill/evict and back-invalidate with statistics.
// ----------------------------------------------------------------------------
// After reset the block sweeps every row of the set memory (valid,
// dirty and tag cleared, ranks set to way number) and takes no request then.
// Each request then passes through these steps from one acceptance to the
// next: the accepting state, one set-memory read, a scan of up to WAYS ways
// through the single shared way-compare unit (a hit ends the scan at the matching
// way), one write back of the whole set and the load of the result
// register. The whole set is one memory word, so one read and one write port
// suffice. A result waits in the output register until taken; the next
// request is accepted meanwhile and holds in its output state only while the
// previous result is still waiting.
// ----------------------------------------------------------------------------
module set_assoc_lru_tag_store_core
    import salru_pkg::*;
#(
    parameter int SET_COUNT  = NumSetsDef,
    parameter int WAYS       = WaysDef,
    parameter int LINE_BYTES = LineBytesDef,
    parameter int ADDR_BITS  = AddrBitsDef
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // tdata: address[31:0], acc_kind[33:32], is_fill[34], zero pad
    input  logic [InDataW-1:0]  s_tdata,
    // tuser: command
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // tdata: hit, victim_valid, victim_addr[33:2], victim_dirty, inval_dirty,
    // count_accesses, count_hits, count_misses, count_writes,
    // count_writebacks, zero pad
    output logic [OutDataW-1:0] m_tdata
);

    localparam int OFF_W  = $clog2(LINE_BYTES + 1) - 1;
    localparam int SET_W0 = $clog2(SET_COUNT + 1) - 1;
    localparam int SET_W  = (SET_W0 < 1) ? 1 : SET_W0;
    localparam int TSHIFT = OFF_W + SET_W0;
    localparam int TAG_W  = ADDR_BITS - TSHIFT;
    localparam int RANK_W = (WAYS < 2) ? 1 : $clog2(WAYS);
    localparam int WAY_W  = RANK_W;
    localparam int CNT_W  = $clog2(WAYS + 1);
    localparam int LINE_W = 2 + TAG_W + RANK_W;
    localparam int ROW_W  = WAYS * LINE_W;
    localparam int DEPTH  = 1 << SET_W0;

    // ---- set memory: one row per set ----
    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] rd_row_reg;
    logic [ROW_W-1:0] wr_row;
    logic             wr_en;
    logic [SET_W-1:0] wr_addr;

    state_t state_reg, state_next;

    logic [SET_W-1:0]    clr_reg, clr_next;
    logic                cmd_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [1:0]          type_reg;
    logic                fill_reg;
    logic [CNT_W-1:0]    way_reg, way_next;
    logic                hit_reg, hit_next;
    logic [WAY_W-1:0]    hway_reg, hway_next;
    logic                inv_reg, inv_next;
    logic [WAY_W-1:0]    iway_reg, iway_next;
    logic [RANK_W-1:0]   best_reg, best_next;
    logic [WAY_W-1:0]    lway_reg, lway_next;

    logic [31:0] c_acc_reg, c_hit_reg, c_miss_reg, c_wr_reg, c_wb_reg;
    logic        m_valid_reg;
    logic [OutDataW-1:0] m_data_reg;
    logic        out_free;

    logic [TAG_W-1:0] req_tag;
    logic [SET_W-1:0] req_set;

    logic [ADDR_BITS-1:0] s_addr;

    assign s_addr = ADDR_BITS'(s_tdata[31:0]);
    assign req_tag = addr_reg[ADDR_BITS-1:TSHIFT];
    generate
        if (SET_W0 > 0)
        begin : g_set
            assign req_set = addr_reg[TSHIFT-1:OFF_W];
        end
        else
        begin : g_noset
            assign req_set = '0;
        end
    endgenerate

    // ---- unpack the row ----
    logic              f_valid [WAYS];
    logic              f_dirty [WAYS];
    logic [TAG_W-1:0]  f_tag   [WAYS];
    logic [RANK_W-1:0] f_rank  [WAYS];

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            f_valid[w] = rd_row_reg[w*LINE_W + LINE_W - 1];
            f_dirty[w] = rd_row_reg[w*LINE_W + LINE_W - 2];
            f_tag[w]   = rd_row_reg[w*LINE_W + RANK_W +: TAG_W];
            f_rank[w]  = rd_row_reg[w*LINE_W +: RANK_W];
        end
    end

    // ---- shared compare unit on the current way ----
    logic [WAY_W-1:0] cur_way;
    logic u_match, u_invalid, u_ge;

    assign cur_way = way_reg[WAY_W-1:0];

    salru_way_unit #(.TAG_W(TAG_W), .RANK_W(RANK_W)) u_way
    (
        .valid     (f_valid[cur_way]),
        .tag       (f_tag[cur_way]),
        .req_tag   (req_tag),
        .rank      (f_rank[cur_way]),
        .best_rank (best_reg),
        .match     (u_match),
        .invalid   (u_invalid),
        .rank_ge   (u_ge)
    );

    // ---- decisions after the scan ----
    logic             do_fill;
    logic [WAY_W-1:0] tgt_way;
    logic             evict;
    logic             counted;
    logic             v_dirty;
    logic [ADDR_BITS-1:0] v_addr;
    logic             i_dirty;

    always_comb
    begin
        do_fill = !cmd_reg && !hit_reg && fill_reg;
        evict   = do_fill && !inv_reg;
        tgt_way = hit_reg ? hway_reg : (inv_reg ? iway_reg : lway_reg);
        v_dirty = evict && f_dirty[lway_reg];
        v_addr  = '0;
        if (evict)
        begin
            v_addr = ADDR_BITS'({f_tag[lway_reg], req_set} << OFF_W);
            if (SET_W0 == 0)
            begin
                v_addr = ADDR_BITS'(f_tag[lway_reg]) << TSHIFT;
            end
        end
        i_dirty = cmd_reg && hit_reg && f_dirty[hway_reg];
        counted = !cmd_reg && ((hit_reg && !fill_reg) || (fill_reg && type_reg != AccWback));
    end

    // ---- new row for write back ----
    always_comb
    begin
        logic             mru;
        logic [RANK_W-1:0] r0;
        logic              nv, nd;
        logic [TAG_W-1:0]  nt;
        logic [RANK_W-1:0] nr;
        mru = !cmd_reg && (do_fill || (hit_reg && type_reg != AccWback));
        r0  = f_rank[tgt_way];
        wr_row = rd_row_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            nv = f_valid[w];
            nd = f_dirty[w];
            nt = f_tag[w];
            nr = f_rank[w];
            if (mru && f_rank[w] < r0)
            begin
                nr = f_rank[w] + RANK_W'(1);
            end
            if (WAY_W'(w) == tgt_way)
            begin
                if (cmd_reg && hit_reg)
                begin
                    nv = 1'b0;
                    nd = 1'b0;
                end
                else if (!cmd_reg && hit_reg)
                begin
                    if (type_reg == AccWrite || type_reg == AccWback)
                    begin
                        nd = 1'b1;
                    end
                    if (mru)
                    begin
                        nr = '0;
                    end
                end
                else if (do_fill)
                begin
                    nv = 1'b1;
                    nd = (type_reg == AccWrite);
                    nt = req_tag;
                    nr = '0;
                end
            end
            wr_row[w*LINE_W +: LINE_W] = {nv, nd, nt, nr};
        end
    end

    // ---- reset row for clearing sweep ----
    logic [ROW_W-1:0] clr_row;
    always_comb
    begin
        clr_row = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            clr_row[w*LINE_W +: RANK_W] = RANK_W'(w);
        end
    end

    // ---- memory write/read ----
    always_comb
    begin
        wr_en   = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
        wr_addr = (state_reg == ST_CLEAR) ? clr_reg : req_set;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr[SET_W0 > 0 ? SET_W0-1 : 0:0]] <= (state_reg == ST_CLEAR) ? clr_row : wr_row;
        end
        rd_row_reg <= mem[req_set[SET_W0 > 0 ? SET_W0-1 : 0:0]];
    end

    // ---- next state ----
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == SET_W'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (s_tvalid && s_tready) state_next = ST_READ;
            ST_READ:  state_next = ST_SCAN;
            ST_SCAN:  if (way_reg == CNT_W'(WAYS - 1) || (hit_next && !hit_reg))
                          state_next = ST_WRITE;
            ST_WRITE: state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // ---- scan bookkeeping ----
    always_comb
    begin
        clr_next  = clr_reg;
        way_next  = way_reg;
        hit_next  = hit_reg;
        hway_next = hway_reg;
        inv_next  = inv_reg;
        iway_next = iway_reg;
        best_next = best_reg;
        lway_next = lway_reg;
        unique case (state_reg)
            ST_CLEAR: clr_next = clr_reg + SET_W'(1);
            ST_READ:
            begin
                way_next  = '0;
                hit_next  = 1'b0;
                inv_next  = 1'b0;
                best_next = '0;
                lway_next = '0;
            end
            ST_SCAN:
            begin
                way_next = way_reg + CNT_W'(1);
                if (u_match)
                begin
                    hit_next  = 1'b1;
                    hway_next = cur_way;
                end
                else if (u_invalid)
                begin
                    inv_next  = 1'b1;
                    iway_next = cur_way;
                end
                if (u_ge)
                begin
                    best_next = f_rank[cur_way];
                    lway_next = cur_way;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            c_acc_reg   <= '0;
            c_hit_reg   <= '0;
            c_miss_reg  <= '0;
            c_wr_reg    <= '0;
            c_wb_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            // advance statistics and load the result
            if (state_reg == ST_WRITE)
            begin
                if (counted)
                begin
                    c_acc_reg <= c_acc_reg + 32'd1;
                    if (hit_reg) c_hit_reg <= c_hit_reg + 32'd1;
                    else         c_miss_reg <= c_miss_reg + 32'd1;
                    if (type_reg == AccWrite) c_wr_reg <= c_wr_reg + 32'd1;
                end
                if (v_dirty) c_wb_reg <= c_wb_reg + 32'd1;
            end
            if (state_reg == ST_OUT && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    // hold request and scan payload
    logic             o_hit_reg, o_vv_reg, o_vd_reg, o_id_reg;
    logic [31:0]      o_va_reg;

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg  <= s_tuser;
            addr_reg <= s_addr;
            type_reg <= s_tdata[33:32];
            fill_reg <= s_tdata[34];
        end
        way_reg  <= way_next;
        hit_reg  <= hit_next;
        hway_reg <= hway_next;
        inv_reg  <= inv_next;
        iway_reg <= iway_next;
        best_reg <= best_next;
        lway_reg <= lway_next;
        if (state_reg == ST_WRITE)
        begin
            o_hit_reg <= hit_reg;
            o_vv_reg  <= evict;
            o_va_reg  <= 32'(v_addr);
            o_vd_reg  <= v_dirty;
            o_id_reg  <= i_dirty;
        end
        if (state_reg == ST_OUT && out_free)
        begin
            m_data_reg <= {4'd0, c_wb_reg, c_wr_reg, c_miss_reg, c_hit_reg, c_acc_reg,
                           o_id_reg, o_vd_reg, o_va_reg, o_vv_reg, o_hit_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: hw/rtl/salru_way_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_way_unit: shared per-way compare unit
// Examines one way per cycle: tag match, invalid flag, LRU rank order.
// ----------------------------------------------------------------------------
module salru_way_unit
    import salru_pkg::*;
#(
    parameter int TAG_W  = 20,
    parameter int RANK_W = 3
)
(
    input  logic              valid,
    input  logic [TAG_W-1:0]  tag,
    input  logic [TAG_W-1:0]  req_tag,
    input  logic [RANK_W-1:0] rank,
    input  logic [RANK_W-1:0] best_rank,
    output logic              match,
    output logic              invalid,
    output logic              rank_ge
);

    // compare one way against the request
    always_comb
    begin
        match   = valid && (tag == req_tag);
        invalid = !valid;
        rank_ge = rank >= best_rank;
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the LRU tag store core
// Drives access and back-invalidate requests over the input stream, predicts
// hit, victim, dirty and statistics fields with a behavioural copy of the tag
// store, and compares every result field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
    import salru_pkg::*;

    localparam int SETS     = NumSetsDef;
    localparam int NWAYS    = WaysDef;
    localparam int OFF_BITS = $clog2(LineBytesDef);
    localparam int SET_BITS = $clog2(NumSetsDef);
    localparam int TAG_BITS = 32 - OFF_BITS - SET_BITS;
    localparam bit CMD_ACCESS = 1'b0;
    localparam bit CMD_INVAL  = 1'b1;

    typedef struct packed {
        logic        hit;
        logic        victim_valid;
        logic [31:0] victim_addr;
        logic        victim_dirty;
        logic        inval_dirty;
        logic [31:0] n_acc;
        logic [31:0] n_hit;
        logic [31:0] n_miss;
        logic [31:0] n_write;
        logic [31:0] n_wback;
    } lookup_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [OutDataW-1:0] m_tdata;

    // shadow tag store
    logic                line_v [SETS][NWAYS];
    logic                line_d [SETS][NWAYS];
    logic [TAG_BITS-1:0] line_t [SETS][NWAYS];
    int unsigned         rank   [SETS][NWAYS];
    logic [31:0]         stats  [5];

    lookup_t expected_lookups[$];
    int      errors;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_cycles;

    set_assoc_lru_tag_store_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic void touch_way(int s, int w);
        int unsigned r;
        r = rank[s][w];
        for (int k = 0; k < NWAYS; k++)
            if (rank[s][k] < r)
                rank[s][k]++;
        rank[s][w] = 0;
    endfunction

    // Advance the shadow store by one request and return its result
    function automatic lookup_t cache_lookup(bit cmd, logic [31:0] addr,
                                             logic [1:0] acc, bit fill);
        lookup_t             r;
        int                  s;
        int                  inv_way;
        int                  way;
        int unsigned         best;
        logic [TAG_BITS-1:0] tag;
        r = '0;
        s = int'(addr[OFF_BITS +: SET_BITS]);
        tag = addr[31 -: TAG_BITS];
        inv_way = -1;
        if (cmd == CMD_INVAL)
        begin
            for (int w = 0; w < NWAYS; w++)
                if (line_v[s][w] && line_t[s][w] == tag)
                begin
                    r.hit = 1'b1;
                    r.inval_dirty = line_d[s][w];
                    line_v[s][w] = 1'b0;
                    line_d[s][w] = 1'b0;
                    break;
                end
        end
        else
        begin
            for (int w = 0; w < NWAYS; w++)
            begin
                if (line_v[s][w] && line_t[s][w] == tag)
                begin
                    r.hit = 1'b1;
                    if (acc != AccWback)
                        touch_way(s, w);
                    if (acc == AccWrite || acc == AccWback)
                        line_d[s][w] = 1'b1;
                    break;
                end
                if (!line_v[s][w])
                    inv_way = w;
            end
            if (!r.hit && fill)
            begin
                if (inv_way >= 0)
                    way = inv_way;
                else
                begin
                    best = 0;
                    way = 0;
                    for (int w = 0; w < NWAYS; w++)
                        if (rank[s][w] >= best)
                        begin
                            best = rank[s][w];
                            way = w;
                        end
                    r.victim_valid = 1'b1;
                    r.victim_addr = {line_t[s][way], s[SET_BITS-1:0], {OFF_BITS{1'b0}}};
                    r.victim_dirty = line_d[s][way];
                    if (line_d[s][way])
                        stats[4]++;
                end
                touch_way(s, way);
                line_v[s][way] = 1'b1;
                line_t[s][way] = tag;
                line_d[s][way] = (acc == AccWrite);
            end
            if ((r.hit && !fill) || (fill && acc != AccWback))
            begin
                stats[0]++;
                if (r.hit)
                    stats[1]++;
                else
                    stats[2]++;
                if (acc == AccWrite)
                    stats[3]++;
            end
        end
        r.n_acc = stats[0];
        r.n_hit = stats[1];
        r.n_miss = stats[2];
        r.n_write = stats[3];
        r.n_wback = stats[4];
        return r;
    endfunction

    // Offer one request, hold it until taken and queue its prediction
    task automatic send_request(bit cmd, logic [31:0] addr, logic [1:0] acc, bit fill);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'd0, fill, acc, addr};
        do
            @(posedge clk);
        while (!s_tready);
        expected_lookups.push_back(cache_lookup(cmd, addr, acc, fill));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_lookups.size() != 0)
            @(posedge clk);
    endtask

    // Address built from a small tag pool so that sets fill and evict
    function automatic logic [31:0] pool_addr(int s, int tsel);
        logic [31:0] a;
        a = $urandom;
        a[OFF_BITS +: SET_BITS] = s[SET_BITS-1:0];
        a[31 -: TAG_BITS] = TAG_BITS'(tsel * 32'h9E37 + 5);
        return a;
    endfunction

    task automatic test_directed();
        logic [31:0] a;
        // extremes of the address and every access type, with and without fill
        send_request(CMD_ACCESS, 32'h0000_0000, AccRead, 1'b0);
        send_request(CMD_ACCESS, 32'h0000_0000, AccRead, 1'b1);
        send_request(CMD_ACCESS, 32'h0000_0000, AccWback, 1'b0);
        send_request(CMD_ACCESS, 32'hFFFF_FFFF, AccWrite, 1'b1);
        send_request(CMD_ACCESS, 32'hFFFF_FFC0, AccFetch, 1'b1);
        send_request(CMD_ACCESS, 32'hFFFF_FFFF, AccWback, 1'b1);
        send_request(CMD_ACCESS, 32'h1234_5678, AccWback, 1'b1);
        send_request(CMD_ACCESS, 32'h1234_5678, AccWrite, 1'b0);
        // fill one set past its ways to force dirty and clean evictions
        for (int t = 0; t < NWAYS + 3; t++)
            send_request(CMD_ACCESS, pool_addr(3, t), (t % 2) ? AccWrite : AccRead, 1'b1);
        a = pool_addr(3, NWAYS + 2);
        send_request(CMD_INVAL, a, AccRead, 1'b0);
        send_request(CMD_INVAL, a, AccWrite, 1'b1);
        send_request(CMD_INVAL, 32'hFFFF_FFFF, AccWback, 1'b1);
        // refill the freed way, then a hit on it
        send_request(CMD_ACCESS, a, AccWrite, 1'b1);
        send_request(CMD_ACCESS, a, AccWback, 1'b1);
    endtask

    task automatic test_random(int n);
        int          s;
        bit          cmd;
        logic [31:0] a;
        for (int i = 0; i < n; i++)
        begin
            s = $urandom_range(3) == 0 ? $urandom_range(SETS - 1) : $urandom_range(3);
            a = ($urandom_range(19) == 0) ? $urandom : pool_addr(s, $urandom_range(NWAYS + 4));
            cmd = ($urandom_range(9) == 0) ? CMD_INVAL : CMD_ACCESS;
            send_request(cmd, a, 2'($urandom_range(3)), $urandom_range(3) != 0);
        end
    endtask

    task automatic test_backpressure();
        // receiver stalls while the sender keeps offering
        hold_cycles = 300;
        test_random(20);
        wait_drained();
    endtask

    // Receiver ready, with a long hold-off when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end

    // Compare each taken result with the oldest prediction
    always @(posedge clk)
    begin
        lookup_t got;
        lookup_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[$bits(lookup_t)-1:0] ;
            got = {m_tdata[0], m_tdata[1], m_tdata[33:2], m_tdata[34], m_tdata[35],
                   m_tdata[67:36], m_tdata[99:68], m_tdata[131:100],
                   m_tdata[163:132], m_tdata[195:164]};
            if (expected_lookups.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                exp_r = expected_lookups.pop_front();
                if (got.hit !== exp_r.hit)
                begin
                    $display("%0t: hit exp %0d got %0d", $time, exp_r.hit, got.hit);
                    errors++;
                end
                if (got.victim_valid !== exp_r.victim_valid)
                begin
                    $display("%0t: victim_valid exp %0d got %0d", $time,
                             exp_r.victim_valid, got.victim_valid);
                    errors++;
                end
                if (got.victim_addr !== exp_r.victim_addr)
                begin
                    $display("%0t: victim_addr exp %h got %h", $time,
                             exp_r.victim_addr, got.victim_addr);
                    errors++;
                end
                if (got.victim_dirty !== exp_r.victim_dirty)
                begin
                    $display("%0t: victim_dirty exp %0d got %0d", $time,
                             exp_r.victim_dirty, got.victim_dirty);
                    errors++;
                end
                if (got.inval_dirty !== exp_r.inval_dirty)
                begin
                    $display("%0t: inval_dirty exp %0d got %0d", $time,
                             exp_r.inval_dirty, got.inval_dirty);
                    errors++;
                end
                if (got.n_acc !== exp_r.n_acc)
                begin
                    $display("%0t: count_accesses exp %0d got %0d", $time, exp_r.n_acc, got.n_acc);
                    errors++;
                end
                if (got.n_hit !== exp_r.n_hit)
                begin
                    $display("%0t: count_hits exp %0d got %0d", $time, exp_r.n_hit, got.n_hit);
                    errors++;
                end
                if (got.n_miss !== exp_r.n_miss)
                begin
                    $display("%0t: count_misses exp %0d got %0d", $time, exp_r.n_miss, got.n_miss);
                    errors++;
                end
                if (got.n_write !== exp_r.n_write)
                begin
                    $display("%0t: count_writes exp %0d got %0d", $time,
                             exp_r.n_write, got.n_write);
                    errors++;
                end
                if (got.n_wback !== exp_r.n_wback)
                begin
                    $display("%0t: count_writebacks exp %0d got %0d", $time,
                             exp_r.n_wback, got.n_wback);
                    errors++;
                end
            end
        end
    end

    // Hard limit on run length
    initial
    begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        errors = 0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        rst_n = 1'b0;
        for (int s = 0; s < SETS; s++)
            for (int w = 0; w < NWAYS; w++)
            begin
                line_v[s][w] = 1'b0;
                line_d[s][w] = 1'b0;
                line_t[s][w] = '0;
                rank[s][w] = w;
            end
        for (int k = 0; k < 5; k++)
            stats[k] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        wait_drained();
        test_backpressure();
        send_idle_pct = 30;
        recv_idle_pct = 75;
        test_random(440);
        send_idle_pct = 75;
        recv_idle_pct = 30;
        test_random(440);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(430);

        wait_drained();
        repeat (4 * (NWAYS + 4)) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
